// ===== rtl/csme_pkg.sv =====
// Shared types and constants of the CSR sparse matrix engine.
package csme_pkg;

  localparam int unsigned DEF_MAX_ROWS     = 64;
  localparam int unsigned DEF_MAX_COLS     = 64;
  localparam int unsigned DEF_MAX_NONZEROS = 256;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned ROW_IN_W = 6;
  localparam int unsigned COL_IN_W = 6;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned ANS_W    = 56;
  localparam int unsigned STS_W    = 2;
  localparam int unsigned STORED_W = 9;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned PROD_W   = 2 * VAL_W;
  localparam int unsigned FRAC_W   = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_BUILD  = 3'd1,
    CMD_VECTOR = 3'd2,
    CMD_MUL    = 3'd3,
    CMD_LOOKUP = 3'd4
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_e;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctl_t;

endpackage

// ===== rtl/csme_mac.sv =====
// Multiply and accumulate unit: one Q16.16 product per step, exact sum.
module csme_mac (
  input  logic                                clk_i,
  input  csme_pkg::mac_ctl_t                  ctl_i,
  input  logic signed [csme_pkg::VAL_W-1:0]   a_i,
  input  logic signed [csme_pkg::VAL_W-1:0]   b_i,
  output logic signed [csme_pkg::ANS_W-1:0]   acc_o
);

  logic signed [csme_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [csme_pkg::ANS_W-1:0]  acc_q, acc_d;

  always_comb begin
    prod_d = prod_q;
    acc_d  = acc_q;
    if (ctl_i.mul_en) begin
      prod_d = a_i * b_i;
    end
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (ctl_i.acc_en) begin
      // floor shift back to Q16, then add exactly
      acc_d = acc_q + csme_pkg::ANS_W'(prod_q >>> csme_pkg::FRAC_W);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/csr_sparse_matrix_engine.sv =====
// Add, vector write, unknown or rejected commands go straight to the result; multiply and
// lookup walk the row's stored entries, lookup stopping at the first column match. Build
// clears the counts, counts per row, prefix-sums and scatters via the single-port count memory.
// One item at a time: the next beat is taken the cycle after the result is placed, and a
// result is placed only once the receiver has taken the previous one.
// Reset (async, low) empties staging and the matrix, zeroes the vector, restores counts of 64.
module csr_sparse_matrix_engine #(
  parameter int unsigned MAX_ROWS     = csme_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS     = csme_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_NONZEROS = csme_pkg::DEF_MAX_NONZEROS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [csme_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [csme_pkg::CMD_W-1:0]           cmd_i,
  input  logic [csme_pkg::ROW_IN_W-1:0]        row_index_i,
  input  logic [csme_pkg::COL_IN_W-1:0]        column_index_i,
  input  logic signed [csme_pkg::VAL_W-1:0]    entry_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [csme_pkg::ANS_W-1:0]    answer_o,
  output logic [csme_pkg::STS_W-1:0]           status_o,
  output logic [csme_pkg::STORED_W-1:0]        stored_entries_o
);

  localparam int unsigned ROW_AW = $clog2(MAX_ROWS);
  localparam int unsigned RS_AW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned COL_AW = $clog2(MAX_COLS);
  localparam int unsigned NZ_AW  = $clog2(MAX_NONZEROS);
  localparam int unsigned CNT_W  = $clog2(MAX_NONZEROS + 1);
  localparam int unsigned IDX_W  = (CNT_W > RS_AW) ? CNT_W : RS_AW;

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_DONE    = 20'h00002,
    S_CLR     = 20'h00004,
    S_CNT_RD  = 20'h00008,
    S_CNT_CHK = 20'h00010,
    S_CNT_WR  = 20'h00020,
    S_PFX_RD  = 20'h00040,
    S_PFX_WR  = 20'h00080,
    S_PFX_END = 20'h00100,
    S_SCT_RD  = 20'h00200,
    S_SCT_CHK = 20'h00400,
    S_SCT_WR  = 20'h00800,
    S_RS0     = 20'h01000,
    S_RS1     = 20'h02000,
    S_RS2     = 20'h04000,
    S_ENT_RD  = 20'h08000,
    S_ENT_CHK = 20'h10000,
    S_DNS     = 20'h20000,
    S_MUL     = 20'h40000,
    S_ACC     = 20'h80000
  } state_e;

  // memories
  logic [csme_pkg::ROW_IN_W-1:0] stg_row_mem [MAX_NONZEROS];
  logic [csme_pkg::COL_IN_W-1:0] stg_col_mem [MAX_NONZEROS];
  logic [csme_pkg::VAL_W-1:0]    stg_val_mem [MAX_NONZEROS];
  logic [COL_AW-1:0]             ent_col_mem [MAX_NONZEROS];
  logic [csme_pkg::VAL_W-1:0]    ent_val_mem [MAX_NONZEROS];
  logic [CNT_W-1:0]              cnt_mem     [MAX_ROWS];
  logic [CNT_W-1:0]              rs_mem      [MAX_ROWS + 1];
  logic [csme_pkg::VAL_W-1:0]    dns_mem     [MAX_COLS];
  logic [MAX_COLS-1:0]           dns_vld_q;

  state_e                         state_q, state_d;
  logic [csme_pkg::CFG_W-1:0]     rows_q, cols_q;
  logic [CNT_W-1:0]               stg_cnt_q, stg_cnt_d;
  logic [CNT_W-1:0]               nnz_q, nnz_d;
  logic                           built_q, built_d;
  logic [IDX_W-1:0]               idx_q, idx_d;
  logic [CNT_W-1:0]               end_q, end_d;
  logic [csme_pkg::CMD_W-1:0]     cmd_q, cmd_d;
  logic [csme_pkg::ROW_IN_W-1:0]  row_q, row_d;
  logic [csme_pkg::COL_IN_W-1:0]  col_q, col_d;
  logic signed [csme_pkg::ANS_W-1:0] res_ans_q, res_ans_d;
  logic [csme_pkg::STS_W-1:0]     res_sts_q, res_sts_d;
  logic                           out_vld_q, out_vld_d;
  logic signed [csme_pkg::ANS_W-1:0] ans_q;
  logic [csme_pkg::STS_W-1:0]     sts_q;
  logic [csme_pkg::STORED_W-1:0]  stored_q;

  // registered read data
  logic [csme_pkg::ROW_IN_W-1:0]  stg_row_rd_q;
  logic [csme_pkg::COL_IN_W-1:0]  stg_col_rd_q;
  logic [csme_pkg::VAL_W-1:0]     stg_val_rd_q;
  logic [COL_AW-1:0]              ent_col_rd_q;
  logic [csme_pkg::VAL_W-1:0]     ent_val_rd_q;
  logic [CNT_W-1:0]               cnt_rd_q;
  logic [CNT_W-1:0]               rs_rd_q;
  logic [csme_pkg::VAL_W-1:0]     dns_rd_q;
  logic                           dns_vld_rd_q;

  // memory controls
  logic                           stg_we, ent_we, cnt_we, rs_we, dns_we;
  logic [ROW_AW-1:0]              cnt_addr;
  logic [CNT_W-1:0]               cnt_wd;
  logic [RS_AW-1:0]               rs_addr;
  logic [CNT_W-1:0]               rs_wd;
  logic [COL_AW-1:0]              dns_addr;

  csme_pkg::mac_ctl_t             mac_ctl;
  logic signed [csme_pkg::ANS_W-1:0] acc;
  logic signed [csme_pkg::VAL_W-1:0] mac_b;

  logic in_acc, row_ok, col_ok, stg_ok;
  logic [CNT_W-1:0] rs_val;

  assign in_acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  assign row_ok = (csme_pkg::CFG_W'(row_index_i) < rows_q) &&
                  (32'(row_index_i) < MAX_ROWS);
  assign col_ok = (csme_pkg::CFG_W'(column_index_i) < cols_q) &&
                  (32'(column_index_i) < MAX_COLS);
  assign stg_ok = (csme_pkg::CFG_W'(stg_row_rd_q) < rows_q) &&
                  (32'(stg_row_rd_q) < MAX_ROWS) &&
                  (csme_pkg::CFG_W'(stg_col_rd_q) < cols_q) &&
                  (32'(stg_col_rd_q) < MAX_COLS);

  // row starts read as zero until the first build
  assign rs_val = built_q ? rs_rd_q : '0;

  assign mac_b = dns_vld_rd_q ? dns_rd_q : '0;

  csme_mac u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (ent_val_rd_q),
    .b_i   (mac_b),
    .acc_o (acc)
  );

  always_comb begin
    state_d   = state_q;
    stg_cnt_d = stg_cnt_q;
    nnz_d     = nnz_q;
    built_d   = built_q;
    idx_d     = idx_q;
    end_d     = end_q;
    cmd_d     = cmd_q;
    row_d     = row_q;
    col_d     = col_q;
    res_ans_d = res_ans_q;
    res_sts_d = res_sts_q;
    out_vld_d = out_vld_q && !out_ready_i;
    stg_we    = 1'b0;
    ent_we    = 1'b0;
    cnt_we    = 1'b0;
    rs_we     = 1'b0;
    dns_we    = 1'b0;
    cnt_wd    = '0;
    rs_wd     = nnz_q;
    rs_addr   = idx_q[RS_AW-1:0];
    dns_addr  = ent_col_rd_q;
    mac_ctl   = '0;

    if ((state_q == S_CNT_CHK) || (state_q == S_CNT_WR) ||
        (state_q == S_SCT_CHK) || (state_q == S_SCT_WR)) begin
      cnt_addr = ROW_AW'(stg_row_rd_q);
    end else begin
      cnt_addr = idx_q[ROW_AW-1:0];
    end

    case (state_q)
      S_IDLE: begin
        dns_addr = COL_AW'(column_index_i);
        if (in_acc) begin
          cmd_d     = cmd_i;
          row_d     = row_index_i;
          col_d     = column_index_i;
          res_ans_d = '0;
          res_sts_d = csme_pkg::STS_OK;
          idx_d     = '0;
          state_d   = S_DONE;
          case (csme_pkg::cmd_e'(cmd_i))
            csme_pkg::CMD_ADD: begin
              if (!row_ok || !col_ok) begin
                res_sts_d = csme_pkg::STS_RANGE;
              end else if (32'(stg_cnt_q) == MAX_NONZEROS) begin
                res_sts_d = csme_pkg::STS_FULL;
              end else begin
                stg_we    = 1'b1;
                stg_cnt_d = stg_cnt_q + 1'b1;
              end
            end
            csme_pkg::CMD_BUILD: begin
              state_d = S_CLR;
            end
            csme_pkg::CMD_VECTOR: begin
              if (!col_ok) begin
                res_sts_d = csme_pkg::STS_RANGE;
              end else begin
                dns_we = 1'b1;
              end
            end
            csme_pkg::CMD_MUL: begin
              mac_ctl.clear = 1'b1;
              if (!row_ok) begin
                res_sts_d = csme_pkg::STS_RANGE;
              end else begin
                state_d = S_RS0;
              end
            end
            csme_pkg::CMD_LOOKUP: begin
              if (!row_ok || !col_ok) begin
                res_sts_d = csme_pkg::STS_RANGE;
              end else begin
                state_d = S_RS0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      // build: clear counts
      S_CLR: begin
        cnt_we = 1'b1;
        cnt_wd = '0;
        if (32'(idx_q) == MAX_ROWS - 1) begin
          idx_d   = '0;
          state_d = S_CNT_RD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // build: count per row
      S_CNT_RD: begin
        if (CNT_W'(idx_q) == stg_cnt_q) begin
          idx_d   = '0;
          nnz_d   = '0;
          state_d = S_PFX_RD;
        end else begin
          state_d = S_CNT_CHK;
        end
      end
      S_CNT_CHK: begin
        if (stg_ok) begin
          state_d = S_CNT_WR;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_CNT_RD;
        end
      end
      S_CNT_WR: begin
        cnt_we  = 1'b1;
        cnt_wd  = cnt_rd_q + 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = S_CNT_RD;
      end

      // build: prefix sum, counts become cursors
      S_PFX_RD: begin
        state_d = S_PFX_WR;
      end
      S_PFX_WR: begin
        rs_we  = 1'b1;
        cnt_we = 1'b1;
        cnt_wd = nnz_q;
        nnz_d  = nnz_q + cnt_rd_q;
        if (32'(idx_q) == MAX_ROWS - 1) begin
          state_d = S_PFX_END;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_PFX_RD;
        end
      end
      S_PFX_END: begin
        rs_we   = 1'b1;
        rs_addr = RS_AW'(MAX_ROWS);
        idx_d   = '0;
        built_d = 1'b1;
        state_d = S_SCT_RD;
      end

      // build: scatter
      S_SCT_RD: begin
        if (CNT_W'(idx_q) == stg_cnt_q) begin
          stg_cnt_d = '0;
          state_d   = S_DONE;
        end else begin
          state_d = S_SCT_CHK;
        end
      end
      S_SCT_CHK: begin
        if (stg_ok) begin
          state_d = S_SCT_WR;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SCT_RD;
        end
      end
      S_SCT_WR: begin
        ent_we  = 1'b1;
        cnt_we  = 1'b1;
        cnt_wd  = cnt_rd_q + 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = S_SCT_RD;
      end

      // multiply and lookup: fetch row bounds
      S_RS0: begin
        rs_addr = RS_AW'(row_q);
        state_d = S_RS1;
      end
      S_RS1: begin
        // start bound is back from the first read; ask for the end bound
        rs_addr = RS_AW'(row_q) + 1'b1;
        idx_d   = IDX_W'(rs_val);
        state_d = S_RS2;
      end
      S_RS2: begin
        state_d = S_ENT_RD;
      end
      S_ENT_RD: begin
        if (idx_q == IDX_W'(end_q)) begin
          res_ans_d = (csme_pkg::cmd_e'(cmd_q) == csme_pkg::CMD_MUL) ? acc : '0;
          state_d   = S_DONE;
        end else begin
          state_d = S_ENT_CHK;
        end
      end
      S_ENT_CHK: begin
        if (csme_pkg::cmd_e'(cmd_q) == csme_pkg::CMD_MUL) begin
          state_d = S_DNS;
        end else if (ent_col_rd_q == COL_AW'(col_q)) begin
          res_ans_d = csme_pkg::ANS_W'($signed(ent_val_rd_q));
          state_d   = S_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_ENT_RD;
        end
      end
      S_DNS: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        mac_ctl.mul_en = 1'b1;
        state_d        = S_ACC;
      end
      S_ACC: begin
        mac_ctl.acc_en = 1'b1;
        idx_d          = idx_q + 1'b1;
        state_d        = S_ENT_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (state_q == S_RS2) begin
      end_d = rs_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rows_q    <= csme_pkg::CFG_W'(64);
      cols_q    <= csme_pkg::CFG_W'(64);
      stg_cnt_q <= '0;
      nnz_q     <= '0;
      built_q   <= 1'b0;
      out_vld_q <= 1'b0;
      dns_vld_q <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      stg_cnt_q <= stg_cnt_d;
      nnz_q     <= nnz_d;
      built_q   <= built_d;
      out_vld_q <= out_vld_d;
      idx_q     <= idx_d;
      if (cfg_we_i) begin
        if (csme_pkg::reg_e'(cfg_idx_i) == csme_pkg::REG_ROW_COUNT) begin
          rows_q <= cfg_data_i;
        end else begin
          cols_q <= cfg_data_i;
        end
      end
      if (dns_we) begin
        dns_vld_q[dns_addr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    row_q     <= row_d;
    col_q     <= col_d;
    res_ans_q <= res_ans_d;
    res_sts_q <= res_sts_d;
    end_q     <= end_d;
    if ((state_q == S_DONE) && (!out_vld_q || out_ready_i)) begin
      ans_q    <= res_ans_q;
      sts_q    <= res_sts_q;
      stored_q <= csme_pkg::STORED_W'(nnz_q);
    end
  end

  // memories: one write port each, registered reads
  always_ff @(posedge clk_i) begin
    if (stg_we) begin
      stg_row_mem[stg_cnt_q[NZ_AW-1:0]] <= row_index_i;
      stg_col_mem[stg_cnt_q[NZ_AW-1:0]] <= column_index_i;
      stg_val_mem[stg_cnt_q[NZ_AW-1:0]] <= entry_value_i;
    end
    stg_row_rd_q <= stg_row_mem[idx_q[NZ_AW-1:0]];
    stg_col_rd_q <= stg_col_mem[idx_q[NZ_AW-1:0]];
    stg_val_rd_q <= stg_val_mem[idx_q[NZ_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_col_mem[cnt_rd_q[NZ_AW-1:0]] <= COL_AW'(stg_col_rd_q);
      ent_val_mem[cnt_rd_q[NZ_AW-1:0]] <= stg_val_rd_q;
    end
    ent_col_rd_q <= ent_col_mem[idx_q[NZ_AW-1:0]];
    ent_val_rd_q <= ent_val_mem[idx_q[NZ_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_addr] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[cnt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) begin
      rs_mem[rs_addr] <= rs_wd;
    end
    rs_rd_q <= rs_mem[rs_addr];
  end

  always_ff @(posedge clk_i) begin
    if (dns_we) begin
      dns_mem[dns_addr] <= entry_value_i;
    end
    dns_rd_q     <= dns_mem[dns_addr];
    dns_vld_rd_q <= dns_vld_q[dns_addr];
  end

  assign out_valid_o      = out_vld_q;
  assign answer_o         = ans_q;
  assign status_o         = sts_q;
  assign stored_entries_o = stored_q;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the CSR sparse matrix engine: directed table, then random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROWS = 64;
  localparam int NCOLS = 64;
  localparam int NNZ   = 256;

  typedef struct packed {
    logic [csme_pkg::CMD_W-1:0]    cmd;
    logic [csme_pkg::ROW_IN_W-1:0] row;
    logic [csme_pkg::COL_IN_W-1:0] col;
    logic [csme_pkg::VAL_W-1:0]    val;
  } beat_t;

  typedef struct packed {
    logic [csme_pkg::ANS_W-1:0]    answer;
    logic [csme_pkg::STS_W-1:0]    status;
    logic [csme_pkg::STORED_W-1:0] stored;
  } answer_t;

  typedef struct {
    beat_t   item;
    bit      typed;
    answer_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [csme_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [csme_pkg::CMD_W-1:0] cmd_i = '0;
  logic [csme_pkg::ROW_IN_W-1:0] row_index_i = '0;
  logic [csme_pkg::COL_IN_W-1:0] column_index_i = '0;
  logic signed [csme_pkg::VAL_W-1:0] entry_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [csme_pkg::ANS_W-1:0] answer_o;
  logic [csme_pkg::STS_W-1:0] status_o;
  logic [csme_pkg::STORED_W-1:0] stored_entries_o;

  csr_sparse_matrix_engine dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Shadow state of the engine
  int unsigned         m_rows, m_cols, m_staged;
  logic [5:0]          st_row [NNZ];
  logic [5:0]          st_col [NNZ];
  logic [31:0]         st_val [NNZ];
  int unsigned         starts [NROWS+1];
  logic [5:0]          ent_col [NNZ];
  logic [31:0]         ent_val [NNZ];
  logic signed [31:0]  vec [NCOLS];

  answer_t pending_answers[$];
  int      errors;
  bit      rx_quiet, rx_hold, tx_quiet;

  function automatic void shadow_reset();
    m_rows = 64; m_cols = 64; m_staged = 0;
    foreach (starts[i]) starts[i] = 0;
    foreach (vec[i]) vec[i] = '0;
  endfunction

  function automatic void pack_staging();
    int unsigned cnt [NROWS];
    int unsigned cur [NROWS];
    int unsigned total, r, ur, uc, slot;
    total = 0;
    ur = (m_rows > NROWS) ? NROWS : m_rows;
    uc = (m_cols > NCOLS) ? NCOLS : m_cols;
    foreach (cnt[i]) cnt[i] = 0;
    for (int i = 0; i < m_staged; i++)
      if (st_row[i] < ur && st_col[i] < uc) cnt[st_row[i]]++;
    for (int i = 0; i < NROWS; i++) begin
      starts[i] = total; cur[i] = total; total += cnt[i];
    end
    starts[NROWS] = total;
    for (int i = 0; i < m_staged; i++) begin
      r = st_row[i];
      if (r < ur && st_col[i] < uc) begin
        slot = cur[r];
        cur[r]++;
        ent_col[slot] = st_col[i];
        ent_val[slot] = st_val[i];
      end
    end
    m_staged = 0;
  endfunction

  function automatic answer_t engine_step(beat_t b);
    answer_t a;
    int unsigned ur, uc;
    logic signed [63:0] p, acc;
    ur = (m_rows > NROWS) ? NROWS : m_rows;
    uc = (m_cols > NCOLS) ? NCOLS : m_cols;
    acc = '0;
    a.status = csme_pkg::STS_OK;
    case (b.cmd)
      csme_pkg::CMD_ADD:
        if (b.row >= ur || b.col >= uc) a.status = csme_pkg::STS_RANGE;
        else if (m_staged >= NNZ) a.status = csme_pkg::STS_FULL;
        else begin
          st_row[m_staged] = b.row; st_col[m_staged] = b.col; st_val[m_staged] = b.val;
          m_staged++;
        end
      csme_pkg::CMD_BUILD: pack_staging();
      csme_pkg::CMD_VECTOR:
        if (b.col >= uc) a.status = csme_pkg::STS_RANGE;
        else vec[b.col] = b.val;
      csme_pkg::CMD_MUL:
        if (b.row >= ur) a.status = csme_pkg::STS_RANGE;
        else
          for (int d = starts[b.row]; d < starts[b.row+1]; d++) begin
            p = $signed(ent_val[d]) * vec[ent_col[d]];
            acc += (p >>> csme_pkg::FRAC_W);
          end
      csme_pkg::CMD_LOOKUP:
        if (b.row >= ur || b.col >= uc) a.status = csme_pkg::STS_RANGE;
        else
          for (int d = starts[b.row]; d < starts[b.row+1]; d++)
            if (ent_col[d] == b.col) begin
              acc = $signed(ent_val[d]);
              break;
            end
      default: ;
    endcase
    a.answer = acc[csme_pkg::ANS_W-1:0];
    a.stored = starts[NROWS][csme_pkg::STORED_W-1:0];
    return a;
  endfunction

  task automatic offer(beat_t b, bit typed = 0, answer_t res = '0);
    answer_t a;
    if (!tx_quiet && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!tx_quiet && $urandom_range(99) < 15);
    end
    in_valid_i <= 1'b1;
    cmd_i <= b.cmd; row_index_i <= b.row; column_index_i <= b.col; entry_value_i <= b.val;
    // ready seen between edges holds for the next rising edge
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    a = engine_step(b);
    if (typed && a != res) begin
      $display("%0t table row disagrees with shadow: typed %h/%0d/%0d shadow %h/%0d/%0d",
               $realtime, res.answer, res.status, res.stored, a.answer, a.status, a.stored);
      errors++;
    end
    pending_answers.insert(pending_answers.size(), typed ? res : a);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_reg(csme_pkg::reg_e idx, int unsigned v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v[csme_pkg::CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == csme_pkg::REG_ROW_COUNT) m_rows = v; else m_cols = v;
  endtask

  function automatic beat_t mk(logic [2:0] c, int r, int k, logic [31:0] v);
    beat_t b;
    b.cmd = c;
    b.row = csme_pkg::ROW_IN_W'(r);
    b.col = csme_pkg::COL_IN_W'(k);
    b.val = v;
    return b;
  endfunction

  function automatic answer_t ans(logic [55:0] a, logic [1:0] s, int n);
    answer_t x;
    x.answer = a; x.status = s; x.stored = csme_pkg::STORED_W'(n);
    return x;
  endfunction

  function automatic beat_t rand_beat(int unsigned depth);
    beat_t b;
    int unsigned pick;
    pick = $urandom_range(99);
    b.row = csme_pkg::ROW_IN_W'((pick < 90) ? $urandom_range(depth - 1) : $urandom_range(63));
    b.col = csme_pkg::COL_IN_W'((pick < 90) ? $urandom_range(depth - 1) : $urandom_range(63));
    b.val = $urandom();
    if ($urandom_range(3) == 0) b.val = 32'(($signed($urandom_range(20)) - 10) <<< 16);
    pick = $urandom_range(99);
    if (pick < 40) b.cmd = csme_pkg::CMD_ADD;
    else if (pick < 44) b.cmd = csme_pkg::CMD_BUILD;
    else if (pick < 62) b.cmd = csme_pkg::CMD_VECTOR;
    else if (pick < 80) b.cmd = csme_pkg::CMD_MUL;
    else if (pick < 97) b.cmd = csme_pkg::CMD_LOOKUP;
    else b.cmd = csme_pkg::CMD_W'($urandom_range(7, 5));
    return b;
  endfunction

  // Receive side: random stalls, one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold) out_ready_i <= 1'b0;
      else out_ready_i <= rx_quiet || ($urandom_range(99) >= 15);
    end
  end

  // Sample between edges: a beat seen here is taken at the next rising edge
  initial begin
    answer_t exp_a;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_answers.size() == 0) begin
          $display("%0t unexpected result %h/%0d/%0d", $realtime, answer_o, status_o,
                   stored_entries_o);
          errors++;
        end else begin
          exp_a = pending_answers.pop_front();
          if (answer_o !== exp_a.answer) begin
            $display("%0t answer: expected %h actual %h", $realtime, exp_a.answer, answer_o);
            errors++;
          end
          if (status_o !== exp_a.status) begin
            $display("%0t status: expected %0d actual %0d", $realtime, exp_a.status, status_o);
            errors++;
          end
          if (stored_entries_o !== exp_a.stored) begin
            $display("%0t stored entries: expected %0d actual %0d", $realtime, exp_a.stored,
                     stored_entries_o);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #100000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    row_t plan[$];
    row_t rw;
    int unsigned depth;
    errors = 0; rx_quiet = 0; rx_hold = 0; tx_quiet = 0;
    shadow_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; typed rows can be read off at a glance
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_MUL, 0, 0, 0), 1,
                               ans(0, csme_pkg::STS_OK, 0)});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_LOOKUP, 63, 63, 0), 1,
                               ans(0, csme_pkg::STS_OK, 0)});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_ADD, 0, 0, 32'h7fffffff), 0, '0});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_ADD, 0, 63, 32'h80000000), 0, '0});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_ADD, 63, 0, 32'hffffffff), 0, '0});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_ADD, 0, 0, 32'h00010000), 0, '0});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_ADD, 5, 10, 32'h00020000), 0, '0});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_BUILD, 0, 0, 0), 1,
                               ans(0, csme_pkg::STS_OK, 5)});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_VECTOR, 0, 0, 32'h80000000), 1,
                               ans(0, csme_pkg::STS_OK, 5)});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_VECTOR, 0, 63, 32'h7fffffff), 1,
                               ans(0, csme_pkg::STS_OK, 5)});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_VECTOR, 0, 10, 32'h00030000), 1,
                               ans(0, csme_pkg::STS_OK, 5)});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_MUL, 0, 0, 0), 0, '0});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_MUL, 63, 0, 0), 0, '0});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_MUL, 5, 0, 0), 1,
                               ans(56'h6_0000, csme_pkg::STS_OK, 5)});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_LOOKUP, 0, 0, 0), 1,
                               ans(56'h00_0000_7fff_ffff, csme_pkg::STS_OK, 5)});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_LOOKUP, 0, 63, 0), 1,
                               ans(56'hff_ffff_8000_0000, csme_pkg::STS_OK, 5)});
    plan.insert(plan.size(), '{mk(csme_pkg::CMD_LOOKUP, 5, 11, 0), 1,
                               ans(0, csme_pkg::STS_OK, 5)});
    plan.insert(plan.size(), '{mk(3'd5, 1, 1, 1), 1, ans(0, csme_pkg::STS_OK, 5)});
    plan.insert(plan.size(), '{mk(3'd7, 63, 63, 32'hffffffff), 1,
                               ans(0, csme_pkg::STS_OK, 5)});
    foreach (plan[i]) offer(plan[i].item, plan[i].typed, plan[i].res);
    drain();

    // Narrow sizes: range errors at one-by-one, then the zero-row, 127-column extreme
    set_reg(csme_pkg::REG_ROW_COUNT, 1);
    set_reg(csme_pkg::REG_COL_COUNT, 1);
    offer(mk(csme_pkg::CMD_ADD, 1, 0, 1), 1, ans(0, csme_pkg::STS_RANGE, 5));
    offer(mk(csme_pkg::CMD_ADD, 0, 1, 1), 1, ans(0, csme_pkg::STS_RANGE, 5));
    offer(mk(csme_pkg::CMD_VECTOR, 0, 1, 1), 1, ans(0, csme_pkg::STS_RANGE, 5));
    offer(mk(csme_pkg::CMD_MUL, 1, 0, 0), 1, ans(0, csme_pkg::STS_RANGE, 5));
    offer(mk(csme_pkg::CMD_LOOKUP, 0, 1, 0), 1, ans(0, csme_pkg::STS_RANGE, 5));
    drain();
    set_reg(csme_pkg::REG_ROW_COUNT, 0);
    set_reg(csme_pkg::REG_COL_COUNT, 127);
    offer(mk(csme_pkg::CMD_MUL, 0, 0, 0), 1, ans(0, csme_pkg::STS_RANGE, 5));
    drain();
    set_reg(csme_pkg::REG_ROW_COUNT, 64);
    set_reg(csme_pkg::REG_COL_COUNT, 64);

    // Staging full: 256 accepted then dropped, with the receiver held off
    fork
      begin
        rx_hold = 1;
        repeat (600) @(posedge clk_i);
        rx_hold = 0;
      end
      begin
        tx_quiet = 1;
        for (int i = 0; i < 258; i++)
          offer(mk(csme_pkg::CMD_ADD, $urandom_range(63), $urandom_range(63), $urandom()));
        offer(mk(csme_pkg::CMD_BUILD, 0, 0, 0));
        tx_quiet = 0;
      end
    join
    drain();

    // Random phases over several sizes
    for (int ph = 0; ph < 6; ph++) begin
      depth = (ph % 3 == 0) ? 64 : $urandom_range(2, 16);
      set_reg(csme_pkg::REG_ROW_COUNT, (ph == 5) ? 100 : depth);
      set_reg(csme_pkg::REG_COL_COUNT, depth);
      rx_quiet = (ph == 2);
      tx_quiet = (ph == 2);
      for (int i = 0; i < 150; i++) offer(rand_beat(depth));
      drain();
    end
    rx_quiet = 0; tx_quiet = 0;

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/csme_pkg.sv
rtl/csme_mac.sv
rtl/csr_sparse_matrix_engine.sv
bench/tb.sv
